### rtl/plq_pkg.sv
// Package for the price level order queue: field widths, op and result codes,
// shared command and result structs. No dependencies.
package plq_pkg;
    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ID_W  = 32;
    localparam int VOL_W = 24;
    localparam int TOT_W = 28;
    localparam int PRC_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MATCH  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_ACK      = 3'd0,
        K_FULL     = 3'd1,
        K_CANCEL   = 3'd2,
        K_CREJECT  = 3'd3,
        K_TRADE    = 3'd4,
        K_NOFILL   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [VOL_W-1:0] vol;
        logic [3:0]       slot;
    } t_cmd;

    typedef struct packed {
        t_kind            kind;
        logic [3:0]       slot_out;
        logic [ID_W-1:0]  taker_id;
        logic [ID_W-1:0]  maker_id;
        logic [VOL_W-1:0] fill_qty;
        logic [PRC_W-1:0] trade_price;
        logic [VOL_W-1:0] taker_left;
        logic             cancel_unfilled;
        logic [4:0]       level_count;
        logic [TOT_W-1:0] level_volume;
        logic             last;
    } t_res;
endpackage

### rtl/plq_front.sv
// Front end: accepts input transfers, drops unknown ops, queues commands.
// Depends on plq_pkg.
module plq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  plq_pkg::t_cmd     i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output plq_pkg::t_cmd     o_cmd
);
    import plq_pkg::*;
    // two-entry queue
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && (i_cmd.op != OP_NONE);
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/plq_back.sv
// Back end: slot pool, linked list and match sequencer; one result per cycle while the result register is free.
// Depends on plq_pkg.
module plq_back #(
    parameter int SLOTS = plq_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  plq_pkg::t_cmd             i_cmd,
    input  logic [plq_pkg::PRC_W-1:0] i_price,
    output logic                      o_valid,
    input  logic                      i_ready,
    output plq_pkg::t_res             o_res
);
    import plq_pkg::*;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [ID_W-1:0]  r_ident [SLOTS];
    logic [VOL_W-1:0] r_rem   [SLOTS];
    logic [SW-1:0]    r_next  [SLOTS];
    logic [SW-1:0]    r_prev  [SLOTS];
    logic [SLOTS-1:0] r_used;
    logic [SW-1:0]    r_head, r_tail;
    logic [CW-1:0]    r_count;
    logic [TOT_W-1:0] r_total;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [VOL_W-1:0] r_left;
    logic [4:0]       r_nres;
    t_res   r_out, n_out;
    logic   r_ov;

    logic out_free;
    assign out_free = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_res    = r_out;

    // lowest free slot
    logic [SW-1:0] free_s;
    logic          free_ok;
    always_comb begin
        free_s = '0; free_ok = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin free_s = SW'(i); free_ok = 1'b1; end
        end
    end

    logic          cs_ok;
    logic [SW-1:0] cs;
    assign cs    = SW'(i_cmd.slot);
    assign cs_ok = ({28'd0, i_cmd.slot} < SLOTS) && r_used[cs];

    // head fill
    logic [VOL_W-1:0] h_rem, fill, left_n;
    assign h_rem  = r_rem[r_head];
    assign fill   = (h_rem < r_left) ? h_rem : r_left;
    assign left_n = r_left - fill;

    logic start, step;
    assign o_ready = (r_state == S_IDLE) && out_free;
    assign start   = i_valid && o_ready;
    assign step    = (r_state == S_MATCH) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start && i_cmd.op == OP_MATCH && r_count != '0 && i_cmd.vol != '0)
                n_state = S_MATCH;
            S_MATCH: if (step) begin
                if (left_n == '0 || r_nres == 5'(MAX_RESULTS - 1) ||
                    (fill == h_rem && r_count == CW'(1)))
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a match that will trade produces no result at start
    logic match_go, res_load;
    assign match_go = start && (n_state == S_MATCH);
    assign res_load = (start && !match_go) || step;

    // unlink helper decisions on slot u
    logic [SW-1:0] u;
    logic          do_unlink;
    always_comb begin
        u = r_head; do_unlink = 1'b0;
        if (start && i_cmd.op == OP_CANCEL && cs_ok) begin u = cs; do_unlink = 1'b1; end
        if (step && fill == h_rem) begin u = r_head; do_unlink = 1'b1; end
    end

    always_ff @(posedge i_clk) begin
        if (start && i_cmd.op == OP_INSERT && free_ok) begin
            r_ident[free_s] <= i_cmd.id;
            r_rem[free_s]   <= i_cmd.vol;
            r_next[free_s]  <= '0;
            r_prev[free_s]  <= (r_count == '0) ? '0 : r_tail;
            if (r_count != '0) r_next[r_tail] <= free_s;
        end
        if (step) r_rem[r_head] <= h_rem - fill;
        if (do_unlink) begin
            if (r_count != CW'(1)) begin
                if (u == r_head) r_prev[r_next[u]] <= '0;
                else if (u == r_tail) r_next[r_prev[u]] <= '0;
                else begin
                    r_next[r_prev[u]] <= r_next[u];
                    r_prev[r_next[u]] <= r_prev[u];
                end
            end
            r_next[u] <= '0;
            r_prev[u] <= '0;
        end
        if (start) begin r_cmd <= i_cmd; r_left <= i_cmd.vol; r_nres <= 5'd0; end
        if (step) begin r_left <= left_n; r_nres <= r_nres + 5'd1; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_head <= '0; r_tail <= '0;
            r_count <= '0; r_total <= '0;
        end else begin
            r_state <= n_state;
            if (start && i_cmd.op == OP_INSERT && free_ok) begin
                r_used[free_s] <= 1'b1;
                r_tail <= free_s;
                if (r_count == '0) r_head <= free_s;
                r_count <= r_count + CW'(1);
                r_total <= r_total + TOT_W'(i_cmd.vol);
            end
            if (do_unlink) begin
                r_used[u] <= 1'b0;
                r_count <= r_count - CW'(1);
                if (r_count == CW'(1)) begin r_head <= '0; r_tail <= '0; end
                else if (u == r_head) r_head <= r_next[u];
                else if (u == r_tail) r_tail <= r_prev[u];
            end
            if (start && i_cmd.op == OP_CANCEL && cs_ok)
                r_total <= r_total - TOT_W'(r_rem[cs]);
            if (step) r_total <= r_total - TOT_W'(fill);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (res_load) r_ov <= 1'b1;
        else if (i_ready) r_ov <= 1'b0;
    end

    logic [CW-1:0]    cnt_ins, cnt_dec;
    assign cnt_ins = r_count + CW'(1);
    assign cnt_dec = r_count - CW'(1);

    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        n_out.level_count  = 5'(r_count);
        n_out.level_volume = r_total;
        if (step) begin
            n_out.kind        = K_TRADE;
            n_out.slot_out    = 4'(r_head);
            n_out.taker_id    = r_cmd.id;
            n_out.maker_id    = r_ident[r_head];
            n_out.fill_qty    = fill;
            n_out.trade_price = i_price;
            n_out.taker_left  = left_n;
            n_out.level_count = (fill == h_rem) ? 5'(cnt_dec) : 5'(r_count);
            n_out.level_volume = r_total - TOT_W'(fill);
            n_out.last = (n_state == S_IDLE);
        end else begin
            case (i_cmd.op)
                OP_INSERT: if (free_ok) begin
                    n_out.kind = K_ACK;
                    n_out.slot_out = 4'(free_s);
                    n_out.level_count = 5'(cnt_ins);
                    n_out.level_volume = r_total + TOT_W'(i_cmd.vol);
                end else n_out.kind = K_FULL;
                OP_CANCEL: begin
                    n_out.slot_out = i_cmd.slot;
                    if (cs_ok) begin
                        n_out.kind = K_CANCEL;
                        n_out.cancel_unfilled = (r_rem[cs] != '0);
                        n_out.level_count = 5'(cnt_dec);
                        n_out.level_volume = r_total - TOT_W'(r_rem[cs]);
                    end else n_out.kind = K_CREJECT;
                end
                default: begin
                    // match with nothing to fill; a trading match reports from the sequencer
                    n_out.kind = K_NOFILL;
                    n_out.taker_id = i_cmd.id;
                    n_out.taker_left = i_cmd.vol;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) r_out <= n_out;
    end
endmodule

### rtl/price_level_order_queue_core.sv
// Top level of the price level order queue.
// Ties front queue and back end; depends on plq_pkg, plq_front, plq_back.
//
// Use: one price level of an order book. s_axis carries commands: tuser = op,
//   tdata = order_id[31:0], volume[55:32], slot[59:56], zero pad to 64.
// m_axis carries results: tuser = kind, tdata as listed at the port,
//   tlast on the final result of each command. Op 3 is taken and dropped.
// i_cfg_we/i_cfg_wdata write the level price; write it only while idle (not enforced here).
// Insert, cancel and a match with nothing to fill give one result, passed
// through the command queue and the result register. A match that trades
// first enters its match state, then gives one trade per cycle while the
// receiver takes them, and holds the back end until its last trade.
// A two-entry command queue lets inputs be taken while the back end works.
// Reset clears the pool (all slots free), the list and the totals.
// When the receiver stalls, the result register holds and the back end waits;
// the queue fills, then s_axis_tready drops.
module price_level_order_queue_core #(
    parameter int SLOTS = plq_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_cfg_we,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // op
    input  logic [63:0] s_axis_tdata,   // order_id, volume, slot
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [2:0]  m_axis_tuser,   // kind
    output logic [183:0] m_axis_tdata,  // slot_out, taker_id, maker_id,
                                        // fill_qty, trade_price, taker_left,
                                        // cancel_unfilled, level_count, level_volume
    output logic        m_axis_tlast
);
    import plq_pkg::*;
    logic [PRC_W-1:0] r_price;
    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_price <= '0;
        else if (i_cfg_we) r_price <= i_cfg_wdata;
    end

    assign in_cmd.op   = t_op'(s_axis_tuser);
    assign in_cmd.id   = s_axis_tdata[31:0];
    assign in_cmd.vol  = s_axis_tdata[55:32];
    assign in_cmd.slot = s_axis_tdata[59:56];

    plq_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    plq_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd), .i_price(r_price),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {2'd0, res.level_volume, res.level_count, res.cancel_unfilled,
                           res.taker_left, res.trade_price, res.fill_qty,
                           res.maker_id, res.taker_id, res.slot_out};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule

### rtl/plq_checker.sv
// Port-level checks for price_level_order_queue_core, bound to the top level.
// Depends on plq_pkg and the top level's ports.
module plq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [2:0]   m_axis_tuser,
    input logic [183:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import plq_pkg::*;

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed under stall");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= K_NOFILL)
        else $error("bad kind");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_TRADE |-> m_axis_tlast)
        else $error("non-trade result not last");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[153:149] <= 5'd16)
        else $error("count out of range");
endmodule

bind price_level_order_queue_core plq_checker u_plq_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata,
    .m_axis_tlast
);
